FILE: rtl/assert_macros.svh
// Assertion helpers shared by the drive slew RTL.
// Each use stands on a line of its own and carries its own terminator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger
`define DPDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Condition that must hold in the cycle after the trigger
`define DPDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define DPDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/dpds_pkg.sv
`default_nettype none

package dpds_pkg;

    // Controller constants
    localparam int unsigned DRIVE_STEP     = 9;
    localparam int unsigned SETTLE_WIDE    = 40;
    localparam int unsigned SETTLE_NARROW  = 10;
    localparam int unsigned SETTLE_TIMEOUT = 500;
    localparam int unsigned TICK_MS        = 20;
    localparam int unsigned RATE_LIMIT     = 1;
    localparam int unsigned TIME_MAX       = 1023;
    localparam int unsigned DRIVE_MAX      = 127;
    localparam int unsigned RAW_MAX        = DRIVE_MAX * 256;

    // Field and datapath widths
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned CAP_W       = 20;
    localparam int unsigned WIN_W       = 16;
    localparam int unsigned LIM_W       = 7;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned ERR_W       = POS_W + 1;
    localparam int unsigned ACC_W       = CAP_W + 1;
    localparam int unsigned TIME_W      = 10;
    localparam int unsigned DRV_W       = 8;
    localparam int unsigned RAW_W       = 16;
    localparam int unsigned PROD_W      = ERR_W + GAIN_W + 1;
    localparam int unsigned ACC_PROD_W  = ACC_W + GAIN_W + 1;
    localparam int unsigned SD_PROD_W   = ERR_W + GAIN_W + 2;
    localparam int unsigned SUM_W       = PROD_W + 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = CAP_W;
    localparam int unsigned IN_DATA_W   = 4 * POS_W;
    localparam int unsigned IN_USER_W   = 1;
    localparam int unsigned OUT_DATA_W  = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P          = 3'd0,
        REG_GAIN_I          = 3'd1,
        REG_GAIN_D          = 3'd2,
        REG_SLANT_GAIN_P    = 3'd3,
        REG_SLANT_GAIN_D    = 3'd4,
        REG_INTEGRAL_CAP    = 3'd5,
        REG_INTEGRAL_WINDOW = 3'd6,
        REG_OUTPUT_LIMIT    = 3'd7
    } cfg_reg_t;

    // Stage load strobes: stage n takes the beat held by stage n-1
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/dpds_lane.sv
`default_nettype none
`include "assert_macros.svh"

// One side of the drive: error history, windowed integral, settle timer,
// PID products and the clamped PID sum.
module dpds_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpds_pkg::pipe_ctl_t                 ctl,
    input  logic                                start,
    input  logic signed [dpds_pkg::ERR_W-1:0]   err,
    input  logic [dpds_pkg::GAIN_W-1:0]         gain_p,
    input  logic [dpds_pkg::GAIN_W-1:0]         gain_i,
    input  logic [dpds_pkg::GAIN_W-1:0]         gain_d,
    input  logic [dpds_pkg::CAP_W-1:0]          integral_cap,
    input  logic [dpds_pkg::WIN_W-1:0]          integral_window,
    output logic signed [dpds_pkg::RAW_W-1:0]   raw,
    output logic                                done
);
    import dpds_pkg::*;

    // Drive range in 1/256 units, signed for the clamp
    localparam logic signed [SUM_W-1:0] RAW_LIM = SUM_W'(RAW_MAX);

    // Loop state; it also serves as the stage-1 payload, since it always
    // holds the values of the beat that last entered stage 1
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic signed [ERR_W-1:0]  prev_rate_reg;
    logic signed [ERR_W-1:0]  rate_next;
    logic signed [ACC_W-1:0]  accum_reg;
    logic signed [ACC_W-1:0]  accum_next;
    logic [TIME_W-1:0]        settle_time_reg;
    logic [TIME_W-1:0]        settle_time_next;

    logic signed [ERR_W-1:0]  base_error;
    logic signed [ERR_W-1:0]  base_rate;
    logic signed [ACC_W-1:0]  base_accum;
    logic [TIME_W-1:0]        base_time;
    logic signed [ERR_W:0]    rate_wide;
    logic signed [ERR_W:0]    acc_sum;
    logic signed [ERR_W:0]    cap_s;
    logic [ERR_W-1:0]         err_mag;
    logic [ERR_W-1:0]         rate_mag;
    logic [ERR_W-1:0]         prev_rate_mag;
    logic [TIME_W:0]          time_sum;
    logic                     done_next;

    logic                     done1_reg;
    logic                     done2_reg;
    logic                     done3_reg;

    logic signed [PROD_W-1:0]     p_prod_reg;
    logic signed [PROD_W-1:0]     p_prod_next;
    logic signed [ACC_PROD_W-1:0] i_prod_reg;
    logic signed [ACC_PROD_W-1:0] i_prod_next;
    logic signed [PROD_W-1:0]     d_prod_reg;
    logic signed [PROD_W-1:0]     d_prod_next;
    logic signed [SUM_W-1:0]      pid_sum;
    logic signed [RAW_W-1:0]      raw_reg;
    logic signed [RAW_W-1:0]      raw_next;

    function automatic logic [ERR_W-1:0] mag(input logic signed [ERR_W-1:0] v);
        return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    endfunction

    // Stage 1: derivative, integral and settle test on the new error
    always_comb
    begin
        base_error = start ? '0 : prev_error_reg;
        base_rate  = start ? '0 : prev_rate_reg;
        base_accum = start ? '0 : accum_reg;
        base_time  = start ? '0 : settle_time_reg;

        // saturate the derivative to the error width
        rate_wide = (ERR_W+1)'(err) - (ERR_W+1)'(base_error);
        if (rate_wide[ERR_W] != rate_wide[ERR_W-1])
        begin
            rate_next = rate_wide[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                         : {1'b0, {(ERR_W-1){1'b1}}};
        end
        else
        begin
            rate_next = rate_wide[ERR_W-1:0];
        end

        err_mag       = mag(err);
        rate_mag      = mag(rate_next);
        prev_rate_mag = mag(base_rate);

        // integrate inside the window, clear outside, cap the magnitude
        acc_sum = (ERR_W+1)'(base_accum) + (ERR_W+1)'(err);
        cap_s   = signed'((ERR_W+1)'(integral_cap));
        if (err_mag < ERR_W'(integral_window))
        begin
            if (acc_sum > cap_s)
                accum_next = ACC_W'(cap_s);
            else if (acc_sum < -cap_s)
                accum_next = ACC_W'(-cap_s);
            else
                accum_next = ACC_W'(acc_sum);
        end
        else
        begin
            accum_next = '0;
        end

        // two-band settle test with timeout
        done_next        = 1'b0;
        settle_time_next = base_time;
        time_sum         = (TIME_W+1)'(base_time) + (TIME_W+1)'(TICK_MS);
        if (err_mag < ERR_W'(SETTLE_WIDE))
        begin
            if (err_mag < ERR_W'(SETTLE_NARROW) && rate_mag < ERR_W'(RATE_LIMIT)
                && prev_rate_mag < ERR_W'(RATE_LIMIT))
                done_next = 1'b1;
            else if (base_time > TIME_W'(SETTLE_TIMEOUT))
                done_next = 1'b1;
            else if (time_sum > (TIME_W+1)'(TIME_MAX))
                settle_time_next = TIME_W'(TIME_MAX);
            else
                settle_time_next = TIME_W'(time_sum);
        end
    end

    // Hold loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg  <= '0;
            prev_rate_reg   <= '0;
            accum_reg       <= '0;
            settle_time_reg <= '0;
        end
        else if (ctl.s1)
        begin
            prev_error_reg  <= err;
            prev_rate_reg   <= rate_next;
            accum_reg       <= accum_next;
            settle_time_reg <= settle_time_next;
        end
    end

    // Stage 2: gain products
    always_comb
    begin
        p_prod_next = prev_error_reg * $signed({1'b0, gain_p});
        i_prod_next = accum_reg * $signed({1'b0, gain_i});
        d_prod_next = prev_rate_reg * $signed({1'b0, gain_d});
    end

    // Stage 3: sum and clamp to the drive range in 1/256 units
    always_comb
    begin
        pid_sum = SUM_W'(p_prod_reg) + SUM_W'(i_prod_reg) + SUM_W'(d_prod_reg);
        if (pid_sum > RAW_LIM)
            raw_next = RAW_W'(RAW_MAX);
        else if (pid_sum < -RAW_LIM)
            raw_next = -RAW_W'(RAW_MAX);
        else
            raw_next = RAW_W'(pid_sum);
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ctl.s1)
            done1_reg <= done_next;
        if (ctl.s2)
        begin
            p_prod_reg <= p_prod_next;
            i_prod_reg <= i_prod_next;
            d_prod_reg <= d_prod_next;
            done2_reg  <= done1_reg;
        end
        if (ctl.s3)
        begin
            raw_reg   <= raw_next;
            done3_reg <= done2_reg;
        end
    end

    assign raw  = raw_reg;
    assign done = done3_reg;

endmodule

`default_nettype wire

FILE: rtl/dpds_slant.sv
`default_nettype none

// Side balance term: P and D on the difference of position magnitudes,
// and the sign that decides which side it is taken from.
module dpds_slant (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpds_pkg::pipe_ctl_t                 ctl,
    input  logic                                start,
    input  logic signed [dpds_pkg::POS_W-1:0]   left_position,
    input  logic signed [dpds_pkg::POS_W-1:0]   right_position,
    input  logic signed [dpds_pkg::ERR_W-1:0]   left_err,
    input  logic signed [dpds_pkg::ERR_W-1:0]   right_err,
    input  logic [dpds_pkg::GAIN_W-1:0]         slant_gain_p,
    input  logic [dpds_pkg::GAIN_W-1:0]         slant_gain_d,
    output logic signed [dpds_pkg::SUM_W-1:0]   slant,
    output logic                                left_sub,
    output logic                                start_out
);
    import dpds_pkg::*;

    // Previous difference; doubles as the stage-1 difference payload
    logic signed [ERR_W-1:0]     prev_slant_reg;
    logic signed [ERR_W-1:0]     diff_next;
    logic signed [ERR_W-1:0]     base_slant;
    logic [POS_W-1:0]            left_mag;
    logic [POS_W-1:0]            right_mag;
    logic signed [ERR_W:0]       sd_next;
    logic signed [ERR_W:0]       err_sum;
    logic                        left_sub_next;

    logic signed [ERR_W:0]       sd1_reg;
    logic                        left_sub1_reg;
    logic                        start1_reg;
    logic signed [PROD_W-1:0]    p_prod_reg;
    logic signed [PROD_W-1:0]    p_prod_next;
    logic signed [SD_PROD_W-1:0] d_prod_reg;
    logic signed [SD_PROD_W-1:0] d_prod_next;
    logic                        left_sub2_reg;
    logic                        start2_reg;
    logic signed [SUM_W-1:0]     slant_reg;
    logic                        left_sub3_reg;
    logic                        start3_reg;

    // Stage 1: difference, its change and the error sign
    always_comb
    begin
        left_mag   = left_position[POS_W-1] ? POS_W'(-left_position) : POS_W'(left_position);
        right_mag  = right_position[POS_W-1] ? POS_W'(-right_position)
                                             : POS_W'(right_position);
        diff_next  = $signed({1'b0, left_mag}) - $signed({1'b0, right_mag});
        base_slant = start ? '0 : prev_slant_reg;
        sd_next    = (ERR_W+1)'(diff_next) - (ERR_W+1)'(base_slant);
        err_sum    = (ERR_W+1)'(left_err) + (ERR_W+1)'(right_err);
        left_sub_next = !err_sum[ERR_W] && (err_sum != '0);
    end

    // Hold the previous difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_slant_reg <= '0;
        else if (ctl.s1)
            prev_slant_reg <= diff_next;
    end

    // Stage 2: gain products
    always_comb
    begin
        p_prod_next = prev_slant_reg * $signed({1'b0, slant_gain_p});
        d_prod_next = sd1_reg * $signed({1'b0, slant_gain_d});
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ctl.s1)
        begin
            sd1_reg       <= sd_next;
            left_sub1_reg <= left_sub_next;
            start1_reg    <= start;
        end
        if (ctl.s2)
        begin
            p_prod_reg    <= p_prod_next;
            d_prod_reg    <= d_prod_next;
            left_sub2_reg <= left_sub1_reg;
            start2_reg    <= start1_reg;
        end
        if (ctl.s3)
        begin
            slant_reg     <= SUM_W'(p_prod_reg) + SUM_W'(d_prod_reg);
            left_sub3_reg <= left_sub2_reg;
            start3_reg    <= start2_reg;
        end
    end

    assign slant     = slant_reg;
    assign left_sub  = left_sub3_reg;
    assign start_out = start3_reg;

endmodule

`default_nettype wire

FILE: rtl/dpds_merge.sv
`default_nettype none
`include "assert_macros.svh"

// Merge of both lanes with the balance term: output limit, truncation to
// whole drive steps and acceleration limiting against the last drive.
module dpds_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpds_pkg::pipe_ctl_t                 ctl,
    input  logic signed [dpds_pkg::RAW_W-1:0]   left_raw,
    input  logic signed [dpds_pkg::RAW_W-1:0]   right_raw,
    input  logic                                left_done_in,
    input  logic                                right_done_in,
    input  logic signed [dpds_pkg::SUM_W-1:0]   slant,
    input  logic                                left_sub,
    input  logic                                start,
    input  logic [dpds_pkg::LIM_W-1:0]          output_limit,
    output logic signed [dpds_pkg::DRV_W-1:0]   left_drive,
    output logic signed [dpds_pkg::DRV_W-1:0]   right_drive,
    output logic                                left_done,
    output logic                                right_done
);
    import dpds_pkg::*;

    logic signed [SUM_W:0]     slant_w;
    logic signed [SUM_W:0]     left_w;
    logic signed [SUM_W:0]     right_w;
    logic signed [SUM_W:0]     lim_w;
    logic signed [RAW_W-1:0]   left_lim_next;
    logic signed [RAW_W-1:0]   right_lim_next;

    logic signed [RAW_W-1:0]   left_lim_reg;
    logic signed [RAW_W-1:0]   right_lim_reg;
    logic                      left_done4_reg;
    logic                      right_done4_reg;
    logic                      start4_reg;

    // Last drive of each side; it is also the output payload
    logic signed [DRV_W-1:0]   left_drive_reg;
    logic signed [DRV_W-1:0]   right_drive_reg;
    logic signed [DRV_W-1:0]   left_drive_next;
    logic signed [DRV_W-1:0]   right_drive_next;
    logic signed [DRV_W-1:0]   left_last;
    logic signed [DRV_W-1:0]   right_last;
    logic                      left_done_reg;
    logic                      right_done_reg;

    logic                      step_ok;
    logic                      start_ok;
    logic                      chk_step;
    logic                      chk_start;

    function automatic logic signed [RAW_W-1:0] lim_clamp(
        input logic signed [SUM_W:0] v,
        input logic signed [SUM_W:0] lim
    );
        if (v > lim)
            return RAW_W'(lim);
        if (v < -lim)
            return RAW_W'(-lim);
        return RAW_W'(v);
    endfunction

    // Divide by 256, rounding toward zero
    function automatic logic signed [DRV_W-1:0] to_drive(input logic signed [RAW_W-1:0] v);
        logic signed [RAW_W-1:0] adj;
        adj = v[RAW_W-1] ? v + RAW_W'(255) : v;
        return DRV_W'(adj >>> 8);
    endfunction

    function automatic logic [DRV_W-1:0] mag8(input logic signed [DRV_W-1:0] v);
        return v[DRV_W-1] ? DRV_W'(-v) : DRV_W'(v);
    endfunction

    // Limit growth of magnitude; deceleration passes untouched
    function automatic logic signed [DRV_W-1:0] slew(
        input logic signed [DRV_W-1:0] p,
        input logic signed [DRV_W-1:0] last
    );
        logic [DRV_W:0]        grow;
        logic signed [DRV_W:0] stepped;
        grow = (DRV_W+1)'(mag8(last)) + (DRV_W+1)'(DRIVE_STEP);
        if ((DRV_W+1)'(mag8(p)) > grow)
        begin
            stepped = p[DRV_W-1] ? (DRV_W+1)'(last) - (DRV_W+1)'(DRIVE_STEP)
                                 : (DRV_W+1)'(last) + (DRV_W+1)'(DRIVE_STEP);
            return DRV_W'(stepped);
        end
        return p;
    endfunction

    // Stage 4: apply the balance term and the output limit
    always_comb
    begin
        slant_w = (SUM_W+1)'(slant);
        left_w  = left_sub ? (SUM_W+1)'(left_raw) - slant_w : (SUM_W+1)'(left_raw) + slant_w;
        right_w = left_sub ? (SUM_W+1)'(right_raw) + slant_w : (SUM_W+1)'(right_raw) - slant_w;
        lim_w   = signed'((SUM_W+1)'({output_limit, 8'b0}));
        left_lim_next  = lim_clamp(left_w, lim_w);
        right_lim_next = lim_clamp(right_w, lim_w);
    end

    // Stage 5: truncate and slew against the last drive
    always_comb
    begin
        left_last        = start4_reg ? '0 : left_drive_reg;
        right_last       = start4_reg ? '0 : right_drive_reg;
        left_drive_next  = slew(to_drive(left_lim_reg), left_last);
        right_drive_next = slew(to_drive(right_lim_reg), right_last);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s4)
        begin
            left_lim_reg    <= left_lim_next;
            right_lim_reg   <= right_lim_next;
            left_done4_reg  <= left_done_in;
            right_done4_reg <= right_done_in;
            start4_reg      <= start;
        end
    end

    // Hold last drive and settle flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_drive_reg  <= '0;
            right_drive_reg <= '0;
            left_done_reg   <= 1'b0;
            right_done_reg  <= 1'b0;
        end
        else if (ctl.s5)
        begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
            left_done_reg   <= left_done4_reg;
            right_done_reg  <= right_done4_reg;
        end
    end

    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign left_done   = left_done_reg;
    assign right_done  = right_done_reg;

    // Check signals for the slew limiter
    always_comb
    begin
        step_ok = ((DRV_W+1)'(mag8(left_drive_next))
                   <= (DRV_W+1)'(mag8(left_drive_reg)) + (DRV_W+1)'(DRIVE_STEP))
               && ((DRV_W+1)'(mag8(right_drive_next))
                   <= (DRV_W+1)'(mag8(right_drive_reg)) + (DRV_W+1)'(DRIVE_STEP));
        start_ok = (mag8(left_drive_reg) <= DRV_W'(DRIVE_STEP))
                && (mag8(right_drive_reg) <= DRV_W'(DRIVE_STEP));
        chk_step  = ctl.s5 && !start4_reg;
        chk_start = ctl.s5 && start4_reg;
    end

    `DPDS_ASSERT_IMPLIES(a_slew_step, clk, rst_n, chk_step, step_ok, "drive grew by more than one step")
    `DPDS_ASSERT_NEXT(a_start_step, clk, rst_n, chk_start, start_ok, "first drive after start too big")

endmodule

`default_nettype wire

FILE: rtl/dual_side_pid_drive_slew_unit.sv
// Channel  Signals                          Beat contents
// -------  -------------------------------  -----------------------------------------
// in       s_tvalid s_tready s_tdata s_tuser goals, positions, start flag
// out      m_tvalid m_tready m_tdata         drives and settle flags
// cfg      cfg_we cfg_index cfg_data         gain, cap, window or limit write
//
// One beat per clock sustained while m_tready is high; an accepted beat
// passes the input register, error/integral, products, PID sum, balance
// and limit, slew and output register. Each loop state lives in a single
// stage, so a tick can follow the previous one without waiting for it.
// Reset clears all loop state and sets registers to their reset values.
// Each stage advances when the next one has room, so bubbles close up and
// input beats are taken while a result waits if any stage is empty.
`default_nettype none
`include "assert_macros.svh"

module dual_side_pid_drive_slew_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // left_goal [31:0], right_goal [63:32], left_position [95:64],
    // right_position [127:96]
    input  logic [dpds_pkg::IN_DATA_W-1:0]      s_tdata,
    // start_req [0]
    input  logic [dpds_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_drive [7:0], right_drive [15:8], left_done [16], right_done [17],
    // zero [23:18]
    output logic [dpds_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [dpds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dpds_pkg::*;

    // Configuration
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic [GAIN_W-1:0] slant_gain_p_reg;
    logic [GAIN_W-1:0] slant_gain_d_reg;
    logic [CAP_W-1:0]  integral_cap_reg;
    logic [WIN_W-1:0]  integral_window_reg;
    logic [LIM_W-1:0]  output_limit_reg;

    // Pipeline occupancy: bit 0 is the input register, bit 5 the output
    logic [5:0]        valid_reg;
    logic [5:0]        valid_next;
    logic [6:0]        room;
    logic [5:0]        load;
    pipe_ctl_t         ctl;

    // Input register
    logic signed [ERR_W-1:0] left_err_reg;
    logic signed [ERR_W-1:0] right_err_reg;
    logic signed [POS_W-1:0] left_pos_reg;
    logic signed [POS_W-1:0] right_pos_reg;
    logic                    start_reg;

    logic signed [RAW_W-1:0] left_raw;
    logic signed [RAW_W-1:0] right_raw;
    logic                    left_done_l;
    logic                    right_done_l;
    logic signed [SUM_W-1:0] slant;
    logic                    left_sub;
    logic                    slant_start;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    left_done;
    logic                    right_done;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg          <= '0;
            gain_i_reg          <= '0;
            gain_d_reg          <= '0;
            slant_gain_p_reg    <= '0;
            slant_gain_d_reg    <= '0;
            integral_cap_reg    <= '0;
            integral_window_reg <= '0;
            output_limit_reg    <= LIM_W'(DRIVE_MAX);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:          gain_p_reg          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:          gain_i_reg          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:          gain_d_reg          <= cfg_data[GAIN_W-1:0];
                REG_SLANT_GAIN_P:    slant_gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_SLANT_GAIN_D:    slant_gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_CAP:    integral_cap_reg    <= cfg_data[CAP_W-1:0];
                REG_INTEGRAL_WINDOW: integral_window_reg <= cfg_data[WIN_W-1:0];
                REG_OUTPUT_LIMIT:    output_limit_reg    <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage has room when empty or when its beat moves on
    assign room[6] = m_tready;
    assign room[5] = !valid_reg[5] || room[6];
    assign room[4] = !valid_reg[4] || room[5];
    assign room[3] = !valid_reg[3] || room[4];
    assign room[2] = !valid_reg[2] || room[3];
    assign room[1] = !valid_reg[1] || room[2];
    assign room[0] = !valid_reg[0] || room[1];

    assign load       = {valid_reg[4:0], s_tvalid} & room[5:0];
    assign valid_next = load | (valid_reg & ~room[6:1]);

    assign ctl.s1 = load[1];
    assign ctl.s2 = load[2];
    assign ctl.s3 = load[3];
    assign ctl.s4 = load[4];
    assign ctl.s5 = load[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Capture the beat and form both errors
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            left_err_reg  <= ERR_W'($signed(s_tdata[POS_W-1:0]))
                           - ERR_W'($signed(s_tdata[3*POS_W-1:2*POS_W]));
            right_err_reg <= ERR_W'($signed(s_tdata[2*POS_W-1:POS_W]))
                           - ERR_W'($signed(s_tdata[4*POS_W-1:3*POS_W]));
            left_pos_reg  <= $signed(s_tdata[3*POS_W-1:2*POS_W]);
            right_pos_reg <= $signed(s_tdata[4*POS_W-1:3*POS_W]);
            start_reg     <= s_tuser[0];
        end
    end

    dpds_lane u_lane_left (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .start           (start_reg),
        .err             (left_err_reg),
        .gain_p          (gain_p_reg),
        .gain_i          (gain_i_reg),
        .gain_d          (gain_d_reg),
        .integral_cap    (integral_cap_reg),
        .integral_window (integral_window_reg),
        .raw             (left_raw),
        .done            (left_done_l)
    );

    dpds_lane u_lane_right (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .start           (start_reg),
        .err             (right_err_reg),
        .gain_p          (gain_p_reg),
        .gain_i          (gain_i_reg),
        .gain_d          (gain_d_reg),
        .integral_cap    (integral_cap_reg),
        .integral_window (integral_window_reg),
        .raw             (right_raw),
        .done            (right_done_l)
    );

    dpds_slant u_slant (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .start          (start_reg),
        .left_position  (left_pos_reg),
        .right_position (right_pos_reg),
        .left_err       (left_err_reg),
        .right_err      (right_err_reg),
        .slant_gain_p   (slant_gain_p_reg),
        .slant_gain_d   (slant_gain_d_reg),
        .slant          (slant),
        .left_sub       (left_sub),
        .start_out      (slant_start)
    );

    dpds_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .left_raw      (left_raw),
        .right_raw     (right_raw),
        .left_done_in  (left_done_l),
        .right_done_in (right_done_l),
        .slant         (slant),
        .left_sub      (left_sub),
        .start         (slant_start),
        .output_limit  (output_limit_reg),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .left_done     (left_done),
        .right_done    (right_done)
    );

    assign s_tready = room[0];
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {6'b0, right_done, left_done, right_drive, left_drive};

    `DPDS_ASSERT_IMPLIES(a_drain_ready, clk, rst_n, m_tready, s_tready, "input blocked while output drains")
    `DPDS_ASSERT_IMPLIES(a_drive_range, clk, rst_n, m_tvalid, (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80), "drive outside symmetric range")

endmodule

`default_nettype wire

FILE: tb/dual_side_pid_drive_slew_unit_tb.sv
`timescale 1ns / 100ps

module dual_side_pid_drive_slew_unit_tb;

    import dpds_pkg::*;

    // Local copies of the controller constants as signed 64-bit values
    localparam longint ACCEL       = DRIVE_STEP;
    localparam longint WIDE_BAND   = SETTLE_WIDE;
    localparam longint NARROW_BAND = SETTLE_NARROW;
    localparam longint TIMEOUT_MS  = SETTLE_TIMEOUT;
    localparam longint TICK_STEP   = TICK_MS;
    localparam longint RATE_BAND   = RATE_LIMIT;
    localparam longint SETTLE_CAP  = TIME_MAX;
    localparam longint DRIVE_CLIP  = RAW_MAX;
    localparam longint DERIV_HI    = 64'sd4294967295;
    localparam longint DERIV_LO    = -64'sd4294967296;

    localparam logic signed [31:0] POS_HI = 32'sh7fff_ffff;
    localparam logic signed [31:0] POS_LO = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic              start;
        logic signed [31:0] lgoal;
        logic signed [31:0] rgoal;
        logic signed [31:0] lpos;
        logic signed [31:0] rpos;
    } tick_t;

    typedef struct {
        logic signed [7:0] ldrive;
        logic signed [7:0] rdrive;
        logic              ldone;
        logic              rdone;
    } drive_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata = '0;
    logic [IN_USER_W-1:0]    s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    idle_mode_t idle_mode = IDLE_NONE;
    tick_t      tick_queue[$];
    drive_t     drive_expect[$];
    drive_t     want_beat;
    drive_t     got_beat;
    int         bad_results = 0;
    int         result_count = 0;

    // Register copies
    logic [15:0] kp = '0, ki = '0, kd = '0, kbp = '0, kbd = '0, iwin = '0;
    logic [19:0] icap = '0;
    logic [6:0]  dlim = 7'd127;

    // Loop state copies
    logic signed [32:0] err_last[2] = '{default: '0};
    logic signed [20:0] integ[2] = '{default: '0};
    logic signed [32:0] rate_last[2] = '{default: '0};
    logic signed [7:0]  drive_last[2] = '{default: '0};
    logic [9:0]         settle_ms[2] = '{default: '0};
    logic signed [32:0] balance_last = '0;

    // Register sets: P, I, D, balance P, balance D, cap, window, limit
    logic [19:0] presets[7][8] = '{
        '{20'd256, 20'd16, 20'd128, 20'd32, 20'd64, 20'd5000, 20'd200, 20'd127},
        '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd127},
        '{20'd65535, 20'd65535, 20'd65535, 20'd65535, 20'd65535, 20'd1048575,
          20'd65535, 20'd127},
        '{20'd300, 20'd20, 20'd150, 20'd16, 20'd16, 20'd2000, 20'd300, 20'd0},
        '{20'd1024, 20'd256, 20'd512, 20'd0, 20'd0, 20'd0, 20'd0, 20'd60},
        '{20'd40, 20'd3, 20'd20, 20'd5, 20'd5, 20'd300, 20'd50, 20'd90},
        '{20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1}
    };

    dual_side_pid_drive_slew_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // PID for one side; returns the clamped sum in 1/256 units
    function automatic longint pid_side(input int s, input longint err, output logic done);
        longint d;
        longint ae;
        longint acc;
        longint cap;
        longint raw;
        longint held;
        d = clip(err - longint'(err_last[s]), DERIV_LO, DERIV_HI);
        ae = mag(err);
        cap = longint'(icap);
        err_last[s] = 33'(err);
        if (ae < longint'(iwin))
        begin
            acc = clip(longint'(integ[s]) + err, -cap, cap);
            integ[s] = 21'(acc);
        end
        else
            integ[s] = '0;
        raw = err * longint'(kp) + longint'(integ[s]) * longint'(ki) + d * longint'(kd);
        raw = clip(raw, -DRIVE_CLIP, DRIVE_CLIP);
        // Two-band settle test with timeout
        done = 1'b0;
        if (ae < WIDE_BAND)
        begin
            if (ae < NARROW_BAND && mag(d) < RATE_BAND
                && mag(longint'(rate_last[s])) < RATE_BAND)
                done = 1'b1;
            else if (longint'(settle_ms[s]) > TIMEOUT_MS)
                done = 1'b1;
            else
            begin
                held = longint'(settle_ms[s]) + TICK_STEP;
                settle_ms[s] = 10'((held > SETTLE_CAP) ? SETTLE_CAP : held);
            end
        end
        rate_last[s] = 33'(d);
        return raw;
    endfunction

    // Limit acceleration only; any slow-down passes straight through
    function automatic logic signed [7:0] slew_side(input int s, input longint p);
        longint last;
        last = longint'(drive_last[s]);
        if (mag(p) > mag(last) + ACCEL)
            p = last + ((p > 0) ? ACCEL : -ACCEL);
        drive_last[s] = 8'(p);
        return 8'(p);
    endfunction

    function automatic drive_t control_tick(input tick_t t);
        longint le, re, lraw, rraw, diff, bal, lim;
        logic   dl, dr;
        drive_t r;
        if (t.start)
        begin
            err_last = '{default: '0};
            integ = '{default: '0};
            rate_last = '{default: '0};
            drive_last = '{default: '0};
            settle_ms = '{default: '0};
            balance_last = '0;
        end
        le = longint'(t.lgoal) - longint'(t.lpos);
        re = longint'(t.rgoal) - longint'(t.rpos);
        lraw = pid_side(0, le, dl);
        rraw = pid_side(1, re, dr);
        // Balance term on position magnitudes
        diff = mag(longint'(t.lpos)) - mag(longint'(t.rpos));
        bal = diff * longint'(kbp) + (diff - longint'(balance_last)) * longint'(kbd);
        balance_last = 33'(diff);
        if (le + re > 0)
        begin
            lraw -= bal;
            rraw += bal;
        end
        else
        begin
            lraw += bal;
            rraw -= bal;
        end
        lim = longint'(dlim) * 256;
        lraw = clip(lraw, -lim, lim);
        rraw = clip(rraw, -lim, lim);
        r.ldrive = slew_side(0, lraw / 256);
        r.rdrive = slew_side(1, rraw / 256);
        r.ldone = dl;
        r.rdone = dr;
        return r;
    endfunction

    function automatic string beat_text(input drive_t b);
        return $sformatf("L=%0d R=%0d Ld=%0b Rd=%0b", b.ldrive, b.rdrive, b.ldone, b.rdone);
    endfunction

    function automatic logic sender_gap();
        if (idle_mode == IDLE_SEND)
            return $urandom_range(0, 99) < 84;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 10;
        return 1'b0;
    endfunction

    function automatic logic receiver_stall();
        if (idle_mode == IDLE_RECV)
            return $urandom_range(0, 99) < 84;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 10;
        return 1'b0;
    endfunction

    // Input driver: predict on every accepted beat, then offer the next
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                drive_expect.push_back(control_tick(tick_queue.pop_front()));
            if (!s_tvalid || s_tready)
            begin
                if (tick_queue.size() != 0 && !sender_gap())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tick_queue[0].rpos, tick_queue[0].lpos,
                                 tick_queue[0].rgoal, tick_queue[0].lgoal};
                    s_tuser  <= tick_queue[0].start;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !receiver_stall();
    end

    // Result monitor: compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_beat.ldrive = m_tdata[7:0];
            got_beat.rdrive = m_tdata[15:8];
            got_beat.ldone  = m_tdata[16];
            got_beat.rdone  = m_tdata[17];
            if (drive_expect.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d: no prediction waiting, got %s",
                             result_count, beat_text(got_beat));
            end
            else
            begin
                want_beat = drive_expect.pop_front();
                if (got_beat.ldrive !== want_beat.ldrive || got_beat.rdrive !== want_beat.rdrive
                    || got_beat.ldone !== want_beat.ldone || got_beat.rdone !== want_beat.rdone)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("result %0d: expected %s, got %s", result_count,
                                 beat_text(want_beat), beat_text(got_beat));
                end
            end
            result_count++;
        end
    end

    task automatic add_tick(input logic start, input logic signed [31:0] lg,
                            input logic signed [31:0] rg, input logic signed [31:0] lp,
                            input logic signed [31:0] rp);
        tick_t t;
        t.start = start;
        t.lgoal = lg;
        t.rgoal = rg;
        t.lpos = lp;
        t.rpos = rp;
        tick_queue.push_back(t);
    endtask

    function automatic void set_reg(input cfg_reg_t idx, input logic [19:0] v);
        case (idx)
            REG_GAIN_P:          kp = v[15:0];
            REG_GAIN_I:          ki = v[15:0];
            REG_GAIN_D:          kd = v[15:0];
            REG_SLANT_GAIN_P:    kbp = v[15:0];
            REG_SLANT_GAIN_D:    kbd = v[15:0];
            REG_INTEGRAL_CAP:    icap = v;
            REG_INTEGRAL_WINDOW: iwin = v[15:0];
            REG_OUTPUT_LIMIT:    dlim = v[6:0];
            default:             ;
        endcase
    endfunction

    // Write all eight registers on consecutive cycles
    task automatic load_regs(input logic [19:0] vals[8]);
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            set_reg(cfg_reg_t'(i), vals[i]);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every beat is sent and every result is back, then let the pipe empty
    task automatic drain();
        while (tick_queue.size() != 0 || drive_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // One step of a wheel's approach to its goal
    function automatic int next_error(input int e);
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 600)) - 300;
        case ($urandom_range(0, 4))
            0, 1:    return e * int'($urandom_range(0, 3)) / 4;
            2:       return e;
            3:       return e + int'($urandom_range(0, 8)) - 4;
            default: return -e / 2 + int'($urandom_range(0, 4)) - 2;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_goal();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return int'($urandom_range(0, 20000)) - 10000;
    endfunction

    // Mostly coherent approach runs opened by a start tick, with some noise
    task automatic run_ticks(input int count);
        int                 left_for_run;
        int                 el, er;
        logic signed [31:0] gl, gr;
        logic               fresh;
        left_for_run = 0;
        gl = '0;
        gr = '0;
        el = 0;
        er = 0;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_tick($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
                continue;
            end
            if (left_for_run == 0)
            begin
                left_for_run = $urandom_range(5, 60);
                gl = pick_goal();
                gr = ($urandom_range(0, 1) == 0) ? gl + int'($urandom_range(0, 200)) - 100
                                                 : pick_goal();
                el = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 80)) - 40
                                                 : int'($urandom_range(0, 4000)) - 2000;
                er = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 80)) - 40
                                                 : int'($urandom_range(0, 4000)) - 2000;
                fresh = 1'b1;
            end
            else
            begin
                el = next_error(el);
                er = next_error(er);
                fresh = 1'b0;
            end
            left_for_run--;
            add_tick(fresh, gl, gr, gl - el, gr - er);
        end
    endtask

    initial
    begin
        logic [19:0] vals[8];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        load_regs(presets[0]);

        // Directed beats
        @(negedge clk);
        idle_mode = IDLE_NONE;
        add_tick(1, 0, 0, 0, 0);
        // largest error magnitudes, then a swing that saturates the derivative
        add_tick(0, POS_HI, POS_LO, POS_LO, POS_HI);
        add_tick(0, POS_LO, POS_HI, POS_HI, POS_LO);
        add_tick(0, POS_LO, POS_LO, POS_LO, POS_LO);
        add_tick(0, POS_HI, POS_HI, POS_HI, POS_HI);
        add_tick(0, -1, -1, -1, -1);
        // on target and stopped: settled in the narrow band
        add_tick(1, 1000, -2000, 1000, -2000);
        add_tick(0, 1000, -2000, 1000, -2000);
        // creep in through the integration window and both settle bands
        add_tick(0, 1000, -2000, 950, -1900);
        add_tick(0, 1000, -2000, 960, -1960);
        add_tick(0, 1000, -2000, 975, -1990);
        add_tick(0, 1000, -2000, 995, -1995);
        add_tick(0, 1000, -2000, 1005, -2003);
        add_tick(0, 1000, -2000, 1005, -2003);
        add_tick(0, 1000, -2000, 1005, -2003);
        // balance term with positions of opposite sign
        add_tick(0, -4990, 3010, -5000, 3000);
        // errors summing to zero pick the other balance direction
        add_tick(0, 107, -7, 100, 0);
        // full drive from rest: acceleration limited, then reversal and stop
        add_tick(1, 100000, -100000, 0, 0);
        add_tick(0, 100000, -100000, 0, 0);
        add_tick(0, 100000, -100000, 0, 0);
        add_tick(0, 100000, -100000, 0, 0);
        add_tick(0, -100000, 100000, 0, 0);
        add_tick(0, 0, 0, 0, 0);
        drain();

        // Random phases, each under its own register set, cycling through the idle patterns
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 7)
                vals = presets[ph];
            else
            begin
                vals[0] = $urandom_range(0, 1024);
                vals[1] = $urandom_range(0, 256);
                vals[2] = $urandom_range(0, 1024);
                vals[3] = $urandom_range(0, 64);
                vals[4] = $urandom_range(0, 64);
                vals[5] = $urandom_range(0, 20000);
                vals[6] = $urandom_range(0, 500);
                vals[7] = $urandom_range(0, 127);
            end
            load_regs(vals);
            @(negedge clk);
            idle_mode = idle_mode_t'(ph % 4);
            run_ticks(80);
            drain();
        end

        if (bad_results == 0 && drive_expect.size() == 0)
            $display("dual_side_pid_drive_slew_unit_tb: clean");
        else
            $display("dual_side_pid_drive_slew_unit_tb: errors");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("dual_side_pid_drive_slew_unit_tb: errors");
        $finish;
    end

endmodule
